/* rtl/fdfs_pkg.sv */
// Shared types and constants for the FIFO job dispatcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fdfs_pkg;

  // Queue depth must be a power of two: pointers wrap by overflow.
  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned SERVERS     = 8;
  localparam int unsigned SRV_W       = 3;
  localparam int unsigned TIME_W      = 8;
  localparam int unsigned NUM_W       = 4;
  localparam logic [NUM_W-1:0] NUM_SERVERS_RST = NUM_W'(8);

  typedef struct packed {
    logic              arrive;
    logic [TIME_W-1:0] service_time;
  } in_t;

  typedef struct packed {
    logic              dispatched;
    logic [SRV_W-1:0]  server_index;
    logic [TIME_W-1:0] job_time;
    logic [PTR_W-1:0]  queue_count;
    logic              any_busy;
    logic              dropped;
  } out_t;

  // Token and status rippling along the server cells
  typedef struct packed {
    logic req;
    logic busy;
  } srv_chain_t;

  // Queue status toward the controller
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [PTR_W-1:0] count;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

/* rtl/fifo_dispatch_to_first_free_server.sv */
// Top level of the FIFO job dispatcher: control, config, output register.
// Depends on fdfs_pkg, fdfs_job_queue and fdfs_srv_cell.
//
//   channel | direction | transaction
//   in      | input     | one tick: arrive flag and service time
//   out     | output    | one result per tick: dispatch, count, status
//   cfg     | input     | num_servers write (4 bits)
//
// Each tick passes through ST_IDLE (accept and queue write), ST_READ (queue read),
// then ST_DONE (server update and result load); the queue memory read is registered.
// The next tick is accepted while a result waits in the output register;
// the final cycle stalls while that register is still full.
// Asynchronous active-low reset empties the queue and idles all servers.
`timescale 1ns / 1ps

module fifo_dispatch_to_first_free_server import fdfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [NUM_W-1:0] cfg_data_i
);

  state_e            state_q, state_d;
  logic [NUM_W-1:0]  num_servers_q;
  logic              dropped_q;
  logic              out_valid_q;
  out_t              out_q;
  logic              in_acc;
  logic              step;
  logic              out_free;
  logic              rd_en;
  logic              dispatched;
  logic [TIME_W-1:0] rd_data;
  q_stat_t           q_stat;
  srv_chain_t        chain [SERVERS+1];
  logic [SERVERS-1:0] took;
  logic [SRV_W-1:0]  srv_idx;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // Sequence one tick
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    step    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          step    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the server count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_servers_q <= NUM_SERVERS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_servers_q <= cfg_data_i;
    end
  end

  // Remember whether the arrival was dropped
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dropped_q <= in_data_i.arrive && q_stat.full;
    end
  end

  fdfs_job_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && in_data_i.arrive),
    .push_data_i (in_data_i.service_time),
    .rd_en_i     (rd_en),
    .pop_i       (step && dispatched),
    .rd_data_o   (rd_data),
    .stat_o      (q_stat)
  );

  // Offer the head job down the server chain
  assign chain[0].req  = !q_stat.empty;
  assign chain[0].busy = 1'b0;

  for (genvar i = 0; i < SERVERS; i++) begin : g_cell
    fdfs_srv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (NUM_W'(i) < num_servers_q),
      .step_i     (step),
      .job_time_i (rd_data),
      .chain_i    (chain[i]),
      .chain_o    (chain[i+1]),
      .took_o     (took[i])
    );
  end

  assign dispatched = chain[0].req && !chain[SERVERS].req;

  // Encode the one-hot take vector
  always_comb begin
    srv_idx = '0;
    for (int i = 0; i < SERVERS; i++) begin
      if (took[i]) begin
        srv_idx = srv_idx | SRV_W'(i);
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.dispatched   <= dispatched;
      out_q.server_index <= dispatched ? srv_idx : '0;
      out_q.job_time     <= dispatched ? rd_data : '0;
      out_q.queue_count  <= q_stat.count - PTR_W'(dispatched);
      out_q.any_busy     <= chain[SERVERS].busy;
      out_q.dropped      <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/fdfs_job_queue.sv */
// Circular job queue: memory of service times with head and tail pointers.
// Depends on fdfs_pkg.
`timescale 1ns / 1ps

module fdfs_job_queue import fdfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [TIME_W-1:0] push_data_i,
  input  logic              rd_en_i,
  input  logic              pop_i,
  output logic [TIME_W-1:0] rd_data_o,
  output q_stat_t           stat_o
);

  logic [TIME_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [TIME_W-1:0] rd_q;
  logic [PTR_W-1:0]  tail_nxt;
  logic [PTR_W-1:0]  head_nxt;

  assign tail_nxt = tail_q + PTR_W'(1);
  assign head_nxt = head_q + PTR_W'(1);

  // Status: one slot stays free, so full is tail one behind head
  assign stat_o.full  = (tail_nxt == head_q);
  assign stat_o.empty = (tail_q == head_q);
  assign stat_o.count = tail_q - head_q;

  // Advance pointers on push and pop
  always_comb begin
    tail_d = tail_q;
    head_d = head_q;
    if (push_i && !stat_o.full) begin
      tail_d = tail_nxt;
    end
    if (pop_i) begin
      head_d = head_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '1;
      tail_q <= '1;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Store arrivals and read the slot after head
  always_ff @(posedge clk_i) begin
    if (push_i && !stat_o.full) begin
      mem[tail_nxt] <= push_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[head_nxt];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/fdfs_srv_cell.sv */
// One server cell: countdown register, takes the dispatch token if idle.
// Depends on fdfs_pkg.
`timescale 1ns / 1ps

module fdfs_srv_cell import fdfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              step_i,
  input  logic [TIME_W-1:0] job_time_i,
  input  srv_chain_t        chain_i,
  output srv_chain_t        chain_o,
  output logic              took_o
);

  logic [TIME_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0] start;

  // Take the token when enabled and idle; pass it on otherwise
  assign took_o      = chain_i.req && en_i && (cnt_q == '0);
  assign chain_o.req = chain_i.req && !took_o;

  // Load the job then count down, saturating at zero
  always_comb begin
    start = took_o ? job_time_i : cnt_q;
    cnt_d = (start != '0) ? start - TIME_W'(1) : start;
  end

  assign chain_o.busy = chain_i.busy || (cnt_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/fdfs_checker.sv */
// Port-level checks for the FIFO job dispatcher, bound to the top level.
// Depends on fdfs_pkg and fifo_dispatch_to_first_free_server.
`timescale 1ns / 1ps

module fdfs_checker import fdfs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // No dispatch means zeroed index and time
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.dispatched |->
      out_data_o.server_index == '0 && out_data_o.job_time == '0)
    else $error("idle result carries nonzero index or time");

  // A drop only happens with the queue near full
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dropped |->
      out_data_o.queue_count >= PTR_W'(QUEUE_DEPTH - 2))
    else $error("drop reported with room in the queue");

  // One tick in flight: no accept right after an accept
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted back to back");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind fifo_dispatch_to_first_free_server fdfs_checker u_fdfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* verif/tb.sv */
// Testbench for fifo_dispatch_to_first_free_server: random and directed ticks with a
// tick-level predictor of the job queue and server countdowns.
// Depends on fdfs_pkg and the fifo_dispatch_to_first_free_server RTL.
`timescale 1ns / 1ps

module tb import fdfs_pkg::*; ();

  localparam int unsigned IDLE_PCT   = 14;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_AT    = 400;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned QUIET_LO   = 600;
  localparam int unsigned QUIET_HI   = 800;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [NUM_W-1:0] cfg_data = '0;

  // Predictor state: job queue, server countdowns, enabled server count
  logic [TIME_W-1:0] job_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  q_head = PTR_W'(QUEUE_DEPTH - 1);
  logic [PTR_W-1:0]  q_tail = PTR_W'(QUEUE_DEPTH - 1);
  logic [TIME_W-1:0] countdown [SERVERS] = '{default: '0};
  logic [NUM_W-1:0]  servers_on = NUM_SERVERS_RST;

  in_t  tick_q [$];
  out_t result_q [$];

  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned drops = 0;
  int unsigned dispatches = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_cycles = 0;

  fifo_dispatch_to_first_free_server dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the queue and servers by one tick and return the expected result
  function automatic out_t dispatch_tick(in_t t);
    out_t             r;
    int unsigned      enabled;
    logic [PTR_W-1:0] next_tail;
    bit               placed;
    r = '0;
    placed = 1'b0;
    enabled = (servers_on > SERVERS) ? SERVERS : servers_on;
    next_tail = q_tail + 1'b1;
    if (t.arrive) begin
      if (next_tail == q_head) begin
        r.dropped = 1'b1;
      end else begin
        q_tail = next_tail;
        job_mem[q_tail] = t.service_time;
      end
    end
    // Hand the head job to the lowest idle enabled server
    if (q_head != q_tail) begin
      for (int s = 0; s < SERVERS; s++) begin
        if (!placed && s < enabled && countdown[s] == '0) begin
          placed = 1'b1;
          q_head = q_head + 1'b1;
          r.job_time = job_mem[q_head];
          countdown[s] = r.job_time;
          r.dispatched = 1'b1;
          r.server_index = SRV_W'(s);
        end
      end
    end
    // Run every countdown down, enabled or not
    for (int s = 0; s < SERVERS; s++) begin
      if (countdown[s] != '0) countdown[s] = countdown[s] - 1'b1;
      if (countdown[s] != '0) r.any_busy = 1'b1;
    end
    r.queue_count = q_tail - q_head;
    return r;
  endfunction

  function automatic in_t random_tick(int unsigned arrive_pct, int unsigned max_time,
                                      int unsigned wide_pct);
    in_t t;
    t.arrive = ($urandom_range(99) < arrive_pct);
    if ($urandom_range(99) < wide_pct) t.service_time = TIME_W'($urandom);
    else t.service_time = TIME_W'($urandom_range(max_time));
    return t;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Sender: present queued ticks, predict each accepted transaction
  always @(posedge clk or negedge rst_n) begin
    out_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = dispatch_tick(in_data);
        result_q.push_back(r);
        ticks_sent++;
        drops += r.dropped;
        dispatches += r.dispatched;
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 &&
            ((ticks_sent >= QUIET_LO && ticks_sent < QUIET_HI) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          in_data <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction, stall at random, hold off once
  always @(posedge clk or negedge rst_n) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("result arrived with no tick pending");
          mismatches++;
        end else begin
          want = result_q.pop_front();
          compare_field("dispatched", want.dispatched, out_data.dispatched);
          compare_field("server_index", want.server_index, out_data.server_index);
          compare_field("job_time", want.job_time, out_data.job_time);
          compare_field("queue_count", want.queue_count, out_data.queue_count);
          compare_field("any_busy", want.any_busy, out_data.any_busy);
          compare_field("dropped", want.dropped, out_data.dropped);
        end
      end
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= QUIET_LO && results_seen < QUIET_HI) ||
                     ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("fifo_dispatch_to_first_free_server test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Wait for the block to drain, then write the server count
  task automatic write_servers(input logic [NUM_W-1:0] n);
    while (tick_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    cfg_data <= n;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    servers_on = n;
    cfg_writes++;
  endtask

  task automatic run_phase(input logic [NUM_W-1:0] n, input int unsigned count,
                           input int unsigned arrive_pct, input int unsigned max_time,
                           input int unsigned wide_pct);
    write_servers(n);
    repeat (count) tick_q.push_back(random_tick(arrive_pct, max_time, wide_pct));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: zero and extreme service times, idle ticks, all servers taken
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h00});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'hFF});
    tick_q.push_back('{arrive: 1'b0, service_time: 8'hFF});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h55});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'hAA});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h01});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h80});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'hFE});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'hC8});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'hFF});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h7F});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h0F});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'hF0});
    tick_q.push_back('{arrive: 1'b0, service_time: 8'h00});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h07});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h00});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'h03});
    tick_q.push_back('{arrive: 1'b0, service_time: 8'h5A});
    tick_q.push_back('{arrive: 1'b0, service_time: 8'h00});
    tick_q.push_back('{arrive: 1'b1, service_time: 8'hFF});

    // Two servers while the others still run down their long jobs
    run_phase(4'd2, 150, 50, 15, 10);
    // No server enabled: let a deep backlog build up
    run_phase(4'd0, 180, 100, 3, 0);
    // Count above the server total: drain the backlog
    run_phase(4'd15, 220, 5, 3, 0);
    run_phase(4'd1, 100, 30, 7, 10);
    run_phase(4'd9, 130, 60, 20, 10);
    run_phase(4'd5, 90, 50, 12, 10);
    run_phase(4'd8, 60, 70, 10, 10);

    while (tick_q.size() != 0 || in_valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d ticks over %0d server-count writes: %0d dispatches, %0d drops.",
             ticks_sent, cfg_writes, dispatches, drops);
    if (mismatches == 0) begin
      $display("fifo_dispatch_to_first_free_server test passed");
    end else begin
      $display("fifo_dispatch_to_first_free_server test failed");
    end
    $finish;
  end

endmodule
